>>> src/ecal_pkg.sv
`timescale 1ns / 1ps

package ecal_pkg;

    // Datapath widths
    localparam int EpochW   = 32;
    localparam int RemW     = 17;
    localparam int DaysW    = 16;
    localparam int YearW    = 8;

    // Seconds per day, hour and minute
    localparam logic [EpochW-1:0] SecPerDay  = 32'd86400;
    localparam logic [RemW-1:0]   SecPerHour = 17'd3600;
    localparam logic [RemW-1:0]   SecPerMin  = 17'd60;

    // Reciprocals for floor(n / d) = (n * ceil(2^k / d)) >> k over each operand range:
    // days  = (secs >> 7) / 675, k = 35, operand < 2^25
    // hours = (tod >> 4) / 225,  k = 21, operand < 2^13
    // mins  = (rem >> 2) / 15,   k = 14, operand < 2^10
    localparam logic [25:0] DayRecip  = 26'd50903317;
    localparam logic [13:0] HourRecip = 14'd9321;
    localparam logic [10:0] MinRecip  = 11'd1093;

    // Calendar constants, years counted from 1900
    localparam logic [YearW-1:0] FirstYearOff = 8'd70;
    localparam logic [YearW-1:0] YearOff2100  = 8'd200;
    localparam logic [3:0]       LastMonth    = 4'd11;
    localparam logic [2:0]       EpochWeekday = 3'd4;  // 1970-01-01 was a Thursday
    localparam logic [8:0]       DaysCommon   = 9'd365;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_DAY,
        S_LD_HOUR,
        S_DIV_HOUR,
        S_LD_MIN,
        S_DIV_MIN,
        S_YEAR,
        S_MONTH
    } ecal_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_day;
        logic div_day;
        logic load_hour;
        logic div_hour;
        logic load_min;
        logic div_min;
        logic year_step;
        logic mark_yday;
        logic month_step;
        logic finish;
    } ecal_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic year_done;
        logic month_done;
    } ecal_status_t;

    // Length of a month, February stretched by the leap flag
    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] d;
        begin
            case (mon)
                4'd1:    d = leap ? 5'd29 : 5'd28;
                4'd3:    d = 5'd30;
                4'd5:    d = 5'd30;
                4'd8:    d = 5'd30;
                4'd10:   d = 5'd30;
                default: d = 5'd31;
            endcase
            return d;
        end
    endfunction

    // Weekday advance over a whole month (length mod 7)
    function automatic logic [1:0] month_shift(input logic [3:0] mon, input logic leap);
        logic [1:0] s;
        begin
            case (mon)
                4'd1:    s = leap ? 2'd1 : 2'd0;
                4'd3:    s = 2'd2;
                4'd5:    s = 2'd2;
                4'd8:    s = 2'd2;
                4'd10:   s = 2'd2;
                default: s = 2'd3;
            endcase
            return s;
        end
    endfunction

endpackage

>>> src/ecal_ctrl.sv
`timescale 1ns / 1ps

module ecal_ctrl
    import ecal_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  ecal_status_t status,
    output ecal_cmd_t    cmd,
    output logic         busy
);

    ecal_state_t     state_reg, state_next;

    assign busy     = (state_reg != S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (start) state_next = S_DIV_DAY;
            S_DIV_DAY:  state_next = S_LD_HOUR;
            S_LD_HOUR:  state_next = S_DIV_HOUR;
            S_DIV_HOUR: state_next = S_LD_MIN;
            S_LD_MIN:   state_next = S_DIV_MIN;
            S_DIV_MIN:  state_next = S_YEAR;
            S_YEAR:     if (status.year_done) state_next = S_MONTH;
            S_MONTH:    if (status.month_done) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:     cmd.load_day  = start;
            S_DIV_DAY:  cmd.div_day   = 1'b1;
            S_LD_HOUR:  cmd.load_hour = 1'b1;
            S_DIV_HOUR: cmd.div_hour  = 1'b1;
            S_LD_MIN:   cmd.load_min  = 1'b1;
            S_DIV_MIN:  cmd.div_min   = 1'b1;
            S_YEAR:
            begin
                cmd.year_step = !status.year_done;
                cmd.mark_yday = status.year_done;
            end
            S_MONTH:
            begin
                cmd.month_step = !status.month_done;
                cmd.finish     = status.month_done;
            end
            default:    cmd = '0;
        endcase
    end

endmodule

>>> src/ecal_datapath.sv
`timescale 1ns / 1ps

module ecal_datapath
    import ecal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ecal_cmd_t         cmd,
    input  logic [EpochW-1:0] epoch_seconds,
    output ecal_status_t      status,
    output logic              done,
    output logic [5:0]        second,
    output logic [5:0]        minute,
    output logic [4:0]        hour,
    output logic [2:0]        weekday,
    output logic [7:0]        years_since_1900,
    output logic [8:0]        day_of_year,
    output logic [3:0]        month_index,
    output logic [4:0]        day_of_month
);

    // Constant divides by reciprocal multiply, one step per cycle
    logic [EpochW-1:0] secs_reg;
    logic [RemW-1:0]   rem_reg, rem_next;
    logic [DaysW-1:0]  quo_reg, quo_next;
    logic [50:0]       day_prod;
    logic [26:0]       hour_prod;
    logic [20:0]       min_prod;
    logic [EpochW-1:0] day_secs;
    logic [EpochW-1:0] tod_full;
    logic [RemW-1:0]   hour_secs;
    logic [RemW-1:0]   min_secs;
    logic [RemW-1:0]   sec_left;

    // Calendar walk
    logic [DaysW-1:0] days_reg;
    logic [YearW-1:0] year_reg;
    logic [3:0]       mon_reg;
    logic [2:0]       wd_reg;
    logic [4:0]       hour_reg;
    logic [8:0]       yday_reg;
    logic             leap;
    logic [8:0]       year_len;
    logic [4:0]       mon_len;
    logic [3:0]       wd_year_sum;
    logic [3:0]       wd_mon_sum;
    logic [2:0]       wd_year;
    logic [2:0]       wd_mon;
    logic [5:0]       wd_fin0;
    logic [5:0]       wd_fin1;
    logic [5:0]       wd_fin2;
    logic [5:0]       wd_fin3;

    logic done_reg;

    // Quotients from the reciprocals, remainders by multiply and subtract
    assign day_prod  = {26'b0, secs_reg[31:7]} * {25'b0, DayRecip};
    assign hour_prod = {14'b0, rem_reg[16:4]} * {13'b0, HourRecip};
    assign min_prod  = {11'b0, rem_reg[11:2]} * {10'b0, MinRecip};
    assign day_secs  = {16'b0, quo_reg} * SecPerDay;
    assign tod_full  = secs_reg - day_secs;
    assign hour_secs = {12'b0, quo_reg[4:0]} * SecPerHour;
    assign min_secs  = {11'b0, quo_reg[5:0]} * SecPerMin;
    assign sec_left  = rem_reg - min_secs;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_day)
            quo_next = day_prod[50:35];
        else if (cmd.load_hour)
            rem_next = tod_full[RemW-1:0];
        else if (cmd.div_hour)
            quo_next = {11'b0, hour_prod[25:21]};
        else if (cmd.load_min)
            rem_next = rem_reg - hour_secs;
        else if (cmd.div_min)
            quo_next = {10'b0, min_prod[19:14]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_day)
            secs_reg <= epoch_seconds;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Leap rule over 1970..2106: multiple of 4, and 2100 is the only century
    // in range that is skipped (2000 is leap)
    assign leap     = (year_reg[1:0] == 2'b00) && (year_reg != YearOff2100);
    assign year_len = DaysCommon + {8'b0, leap};
    assign mon_len  = month_days(mon_reg, leap);

    // Weekday of the first day of the next year / month, mod 7
    assign wd_year_sum = {1'b0, wd_reg} + 4'd1 + {3'b0, leap};
    assign wd_year     = (wd_year_sum >= 4'd7) ? 3'(wd_year_sum - 4'd7) : wd_year_sum[2:0];
    assign wd_mon_sum  = {1'b0, wd_reg} + {2'b0, month_shift(mon_reg, leap)};
    assign wd_mon      = (wd_mon_sum >= 4'd7) ? 3'(wd_mon_sum - 4'd7) : wd_mon_sum[2:0];

    // Add day within month (< 31) and fold the sum (< 37) back below 7
    assign wd_fin0 = {3'b0, wd_reg} + {1'b0, days_reg[4:0]};
    assign wd_fin1 = (wd_fin0 >= 6'd28) ? wd_fin0 - 6'd28 : wd_fin0;
    assign wd_fin2 = (wd_fin1 >= 6'd14) ? wd_fin1 - 6'd14 : wd_fin1;
    assign wd_fin3 = (wd_fin2 >= 6'd7)  ? wd_fin2 - 6'd7  : wd_fin2;

    assign status.year_done  = (days_reg < {7'b0, year_len});
    assign status.month_done = (mon_reg == LastMonth) || (days_reg < {11'b0, mon_len});

    // Year and month walk
    always_ff @(posedge clk)
    begin
        if (cmd.load_hour)
        begin
            days_reg <= quo_reg;
            year_reg <= FirstYearOff;
            wd_reg   <= EpochWeekday;
        end
        else if (cmd.year_step)
        begin
            days_reg <= days_reg - {7'b0, year_len};
            year_reg <= year_reg + 1'b1;
            wd_reg   <= wd_year;
        end
        else if (cmd.month_step)
        begin
            days_reg <= days_reg - {11'b0, mon_len};
            mon_reg  <= mon_reg + 1'b1;
            wd_reg   <= wd_mon;
        end

        if (cmd.load_min)
            hour_reg <= quo_reg[4:0];

        if (cmd.mark_yday)
        begin
            yday_reg <= days_reg[8:0];
            mon_reg  <= '0;
        end
    end

    // Result registers, updated once per item
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            second           <= sec_left[5:0];
            minute           <= quo_reg[5:0];
            hour             <= hour_reg;
            weekday          <= wd_fin3[2:0];
            years_since_1900 <= year_reg;
            day_of_year      <= yday_reg;
            month_index      <= mon_reg;
            day_of_month     <= days_reg[4:0] + 5'd1;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    assign done = done_reg;

endmodule

>>> src/epoch_seconds_to_calendar_core.sv
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00 UTC into
// broken-down UTC calendar time. Pulse start with epoch_seconds while busy is
// low; the beat is taken at that edge. The result appears on the output ports
// together with a one-cycle done strobe; there is no backpressure, so the
// receiver must capture it in that cycle (the outputs then hold until the next
// result). A conversion splits out days, hours and minutes by reciprocal
// multiplies, then walks the calendar one step per whole year after 1970
// (0..136) and one per month before the result's zero-based month (0..11),
// each walk closed by a final check, and last loads the result register.
// busy falls in the cycle of the done strobe, so a new beat can be started then.
module epoch_seconds_to_calendar_core
    import ecal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] epoch_seconds,
    output logic        done,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [2:0]  weekday,
    output logic [7:0]  years_since_1900,
    output logic [8:0]  day_of_year,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month
);

    ecal_cmd_t    cmd;
    ecal_status_t status;

    ecal_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ecal_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .epoch_seconds    (epoch_seconds),
        .status           (status),
        .done             (done),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .weekday          (weekday),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .month_index      (month_index),
        .day_of_month     (day_of_month)
    );

endmodule

>>> src/ecal_checker.sv
`timescale 1ns / 1ps

module ecal_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [5:0] second,
    input logic [5:0] minute,
    input logic [4:0] hour,
    input logic [2:0] weekday,
    input logic [8:0] day_of_year,
    input logic [3:0] month_index,
    input logic [4:0] day_of_month
);

    // An accepted beat keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepted beat");

    // A result only closes a conversion in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a conversion in progress");

    // One result per item
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Time and date fields stay in range
    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24) &&
                 (weekday < 3'd7) && (month_index < 4'd12) && (day_of_month != 5'd0))
        else $error("result field out of range");

    // In January the day of year follows the day of month
    a_january: assert property (@(posedge clk) disable iff (!rst_n)
        done && (month_index == 4'd0) |-> (day_of_year == {4'b0, day_of_month} - 9'd1))
        else $error("day of year disagrees with January date");

endmodule

bind epoch_seconds_to_calendar_core ecal_checker u_ecal_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .second       (second),
    .minute       (minute),
    .hour         (hour),
    .weekday      (weekday),
    .day_of_year  (day_of_year),
    .month_index  (month_index),
    .day_of_month (day_of_month)
);

>>> sim/ecal_result_checker.sv
`timescale 1ns / 1ps

// Watches the command and result channels of the calendar core. It predicts the
// broken-down UTC time for every accepted beat and compares each done strobe
// against the oldest prediction.
module ecal_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] epoch_seconds,
    input  logic        done,
    input  logic [5:0]  second,
    input  logic [5:0]  minute,
    input  logic [4:0]  hour,
    input  logic [2:0]  weekday,
    input  logic [7:0]  years_since_1900,
    input  logic [8:0]  day_of_year,
    input  logic [3:0]  month_index,
    input  logic [4:0]  day_of_month,
    output int          mismatches,
    output int          pending,
    output int          results_seen
);

    localparam int unsigned SecsPerDay  = 86400;
    localparam int unsigned SecsPerHour = 3600;
    localparam int unsigned SecsPerMin  = 60;
    localparam int unsigned EpochYear   = 1970;
    localparam int unsigned YearBase    = 1900;
    localparam int unsigned EpochDow    = 4;   // day zero was a Thursday
    localparam int unsigned February    = 1;
    localparam int unsigned December    = 11;

    localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } utc_time_t;

    utc_time_t expected_dates [$];

    // Gregorian rule: every 4th year, centuries only when divisible by 400
    function automatic int unsigned leap_year(input int unsigned y);
        if (y % 4 != 0)
            return 0;
        if (y % 100 != 0)
            return 1;
        return (y % 400 == 0) ? 1 : 0;
    endfunction

    function automatic int unsigned month_length(input int unsigned m, input int unsigned leap);
        return MonthDays[m] + ((m == February) ? leap : 0);
    endfunction

    // Full conversion of one timestamp
    function automatic utc_time_t utc_fields_of(input logic [31:0] secs);
        int unsigned tod;
        int unsigned days;
        int unsigned year;
        int unsigned leap;
        int unsigned mon;
        utc_time_t   t;
        tod       = secs % SecsPerDay;
        days      = secs / SecsPerDay;
        t.second  = 6'(tod % SecsPerMin);
        t.minute  = 6'((tod % SecsPerHour) / SecsPerMin);
        t.hour    = 5'(tod / SecsPerHour);
        t.weekday = 3'((days + EpochDow) % 7);

        // strip whole years
        year = EpochYear;
        while (days >= 365 + leap_year(year))
        begin
            days -= 365 + leap_year(year);
            year++;
        end
        t.day_of_year = 9'(days);

        // strip whole months, never past December
        leap = leap_year(year);
        mon  = 0;
        while (mon < December && days >= month_length(mon, leap))
        begin
            days -= month_length(mon, leap);
            mon++;
        end
        t.years_since_1900 = 8'(year - YearBase);
        t.month_index      = 4'(mon);
        t.day_of_month     = 5'(days + 1);
        return t;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Results are retired before new beats are queued, so a result and a
    // beat on the same edge stay in order.
    always @(posedge clk or negedge rst_n)
    begin
        utc_time_t exp_t;
        if (!rst_n)
        begin
            expected_dates.delete();
            mismatches    = 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (expected_dates.size() == 0)
                begin
                    $error("result strobe with no beat outstanding");
                    mismatches++;
                end
                else
                begin
                    exp_t = expected_dates.pop_front();
                    check_field("second", 32'(exp_t.second), 32'(second));
                    check_field("minute", 32'(exp_t.minute), 32'(minute));
                    check_field("hour", 32'(exp_t.hour), 32'(hour));
                    check_field("weekday", 32'(exp_t.weekday), 32'(weekday));
                    check_field("years_since_1900", 32'(exp_t.years_since_1900),
                                32'(years_since_1900));
                    check_field("day_of_year", 32'(exp_t.day_of_year), 32'(day_of_year));
                    check_field("month_index", 32'(exp_t.month_index), 32'(month_index));
                    check_field("day_of_month", 32'(exp_t.day_of_month),
                                32'(day_of_month));
                end
            end
            if (start && !busy)
                expected_dates.push_back(utc_fields_of(epoch_seconds));
            pending <= expected_dates.size();
        end
    end

endmodule

>>> sim/epoch_seconds_to_calendar_core_tb.sv
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_core_tb;

    localparam int RandomBeats = 600;
    localparam int CycleLimit  = 2_000_000;
    localparam int DrainCycles = 200;

    // Edges of fields, leap and century years, the 2038 wrap and the top of range
    localparam logic [31:0] CornerEpochs [25] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd31535999,   // 1970-12-31 23:59:59
        32'd31536000,   // 1971-01-01
        32'd68169600,   // 1972-02-29
        32'd94694399,   // 1972-12-31 23:59:59
        32'd951782400,  // 2000-02-29
        32'd951868800,  // 2000-03-01
        32'd978307199,  // 2000-12-31 23:59:59
        32'd2147483647, 32'd2147483648,
        32'd4102444800, // 2100-01-01
        32'd4107542399, // 2100-02-28 23:59:59
        32'd4107542400, // 2100-03-01, no Feb 29 in 2100
        32'd4133980799, // 2100-12-31 23:59:59
        32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] epoch_seconds;
    logic        done;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [7:0]  years_since_1900;
    logic [8:0]  day_of_year;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;

    int mismatches;
    int pending;
    int results_seen;
    int beats_sent;
    int burst_left;
    int cycle_count = 0;

    epoch_seconds_to_calendar_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .weekday          (weekday),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .month_index      (month_index),
        .day_of_month     (day_of_month)
    );

    ecal_result_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second           (second),
        .minute           (minute),
        .hour             (hour),
        .weekday          (weekday),
        .years_since_1900 (years_since_1900),
        .day_of_year      (day_of_year),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .mismatches       (mismatches),
        .pending          (pending),
        .results_seen     (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("epoch_seconds_to_calendar_core_tb failed");
            $finish;
        end
    end

    // Offer one beat from a falling edge and hold it until taken, then idle for a random gap, possibly none
    task automatic send_beat(input logic [31:0] secs);
        int gap;
        int r;
        start         <= 1'b1;
        epoch_seconds <= secs;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        beats_sent++;
        @(negedge clk);

        // mostly short gaps, a few long, none inside a burst
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else if (r < 40)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(1, 5);
        else if (r < 97)
            gap = $urandom_range(6, 40);
        else
            gap = $urandom_range(41, 300);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] secs;
        int          kind;
        beats_sent    = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        epoch_seconds = 32'd0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners
        foreach (CornerEpochs[i])
            send_beat(CornerEpochs[i]);

        // random timestamps, biased toward day starts and the ends of the range
        for (int i = 0; i < RandomBeats; i++)
        begin
            if (i % 40 == 0 && $urandom_range(0, 3) == 0)
                burst_left = $urandom_range(10, 30);
            kind = $urandom_range(0, 99);
            if (kind < 50)
                secs = $urandom;
            else if (kind < 70)
                secs = ($urandom_range(0, 49710) * 86400)
                       + ($urandom_range(0, 1) ? 86399 : $urandom_range(0, 3));
            else if (kind < 85)
                secs = 32'hFFFF_FFFF - $urandom_range(0, 200_000_000);
            else
                secs = $urandom_range(0, 100_000_000);
            send_beat(secs);
        end
        start <= 1'b0;

        // drain outstanding results, then watch for strays
        while (pending != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        $display("Converted %0d timestamps (%0d corner cases, %0d random) across 1970-2106;",
                 beats_sent, $size(CornerEpochs), RandomBeats);
        $display("%0d results checked field by field, %0d field mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("epoch_seconds_to_calendar_core_tb passed");
        else
            $display("epoch_seconds_to_calendar_core_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
src/ecal_pkg.sv
src/ecal_ctrl.sv
src/ecal_datapath.sv
src/epoch_seconds_to_calendar_core.sv
src/ecal_checker.sv
sim/ecal_result_checker.sv
sim/epoch_seconds_to_calendar_core_tb.sv
